// File: sv/lprs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprs_pkg: shared types and constants of the locking pin release sequencer
// Item layouts, phase codes, engine states and arithmetic limits.
// ----------------------------------------------------------------------------
package lprs_pkg;

    localparam int CMD_W  = 10;
    localparam int TIM_W  = 8;
    localparam int PH_W   = 3;

    localparam logic [CMD_W-1:0] CMD_MAX = 10'd1023;
    localparam logic [TIM_W-1:0] TIM_MAX = 8'd255;

    // |to - from| * |t - hold| < 1024 * 256, so the product fits 18 bits
    localparam int PROD_W    = 18;
    localparam int MUL_STEPS = TIM_W;
    localparam int DIV_STEPS = PROD_W;
    localparam int CNT_W     = 5;

    typedef enum logic [PH_W-1:0] {
        PH_IDLE = 3'd0,
        PH_HOLD = 3'd1,
        PH_RAMP = 3'd2,
        PH_STAB = 3'd3,
        PH_END  = 3'd4
    } phase_t;

    typedef enum logic [4:0] {
        ENG_IDLE = 5'b00001,
        ENG_MUL  = 5'b00010,
        ENG_DIV  = 5'b00100,
        ENG_FIX  = 5'b01000,
        ENG_WB   = 5'b10000
    } eng_state_t;

    typedef struct packed {
        logic             enable;
        logic [TIM_W-1:0] hold_time;
        logic [TIM_W-1:0] ramp_time;
        logic [TIM_W-1:0] settle_time;
        logic [TIM_W-1:0] attempt_limit;
        logic [CMD_W-1:0] start_command;
        logic [CMD_W-1:0] ramp_from;
        logic [CMD_W-1:0] ramp_to;
        logic [CMD_W-1:0] settle_command;
    } tick_item_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             done_flag;
        logic [PH_W-1:0]  phase_out;
        logic [TIM_W-1:0] attempts_out;
        logic [TIM_W-1:0] timer_out;
    } result_item_t;

endpackage

// File: sv/locking_pin_release_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// locking_pin_release_sequencer_top: phase sequencer for a locking pin release
// Hold, ramp, stabilize and end phases with a bit-serial ramp interpolator.
// ----------------------------------------------------------------------------
// Usage:
//   tick / tick_valid / tick_stall carries one control tick per item: enable
//   plus the current timing and command set-points. result / result_valid /
//   result_stall returns exactly one item per tick: command, done flag,
//   phase, attempt count and timer, all as they stand after the tick.
//   An item moves on a rising edge with valid high and stall low.
// Engine steps:
//   Most ticks go from accept straight to write-back. A tick that interpolates
//   the ramp first runs an 8-step shift-and-add multiplier followed by an
//   18-step restoring divider, one bit per cycle, then a clamp step. A zero
//   ramp span skips both and goes straight to write-back.
//   One tick is in work at a time; tick_stall is high while it is.
// Stalls:
//   The result sits in an output register. The next tick is taken while a
//   result waits; its own result waits in write-back until the register
//   frees up, and the next tick is held off until then.
// Reset:
//   rst_n (async, active low) returns to idle with timer, attempts, command
//   and the done flag cleared and no result pending.
// ----------------------------------------------------------------------------
module locking_pin_release_sequencer_top
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  tick_valid,
    output logic                  tick_stall,
    input  lprs_pkg::tick_item_t  tick,
    output logic                  result_valid,
    input  logic                  result_stall,
    output lprs_pkg::result_item_t result
);

    // ---------------- sequencer state ----------------
    lprs_pkg::phase_t                 phase_reg, phase_next;
    logic [lprs_pkg::TIM_W-1:0]       timer_reg, timer_next;
    logic [lprs_pkg::TIM_W-1:0]       attempts_reg, attempts_next;
    logic [lprs_pkg::CMD_W-1:0]       cmd_reg, cmd_next;
    logic                             finished_reg, finished_next;

    // ---------------- serial arithmetic engine ----------------
    lprs_pkg::eng_state_t             eng_reg, eng_next;
    logic [lprs_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic [lprs_pkg::PROD_W-1:0]      acc_reg, acc_next;     // product, then quotient
    logic [lprs_pkg::PROD_W-1:0]      mcand_reg, mcand_next;
    logic [lprs_pkg::TIM_W-1:0]       mplier_reg, mplier_next;
    logic [lprs_pkg::TIM_W-1:0]       span_reg, span_next;   // |ramp_time - hold_time|
    logic [lprs_pkg::TIM_W-1:0]       rem_reg, rem_next;
    logic [lprs_pkg::CMD_W-1:0]       from_reg, from_next;
    logic                             qneg_reg, qneg_next;

    // ---------------- output register ----------------
    logic                             res_valid_reg, res_valid_next;
    lprs_pkg::result_item_t           res_item_reg, res_item_next;

    logic                             tick_fire;
    logic                             wb_load;

    // ramp operands
    logic [lprs_pkg::TIM_W-1:0]       t_inc;
    logic [lprs_pkg::TIM_W-1:0]       t_sat;
    logic [lprs_pkg::TIM_W-1:0]       att_sat;
    logic [lprs_pkg::TIM_W:0]         dt_s;
    logic [lprs_pkg::TIM_W:0]         span_s;
    logic [lprs_pkg::CMD_W:0]         diff_s;
    logic [lprs_pkg::TIM_W-1:0]       dt_mag;
    logic [lprs_pkg::TIM_W-1:0]       span_mag;
    logic [lprs_pkg::CMD_W-1:0]       diff_mag;
    logic                             prod_neg;

    // divider / clamp step
    logic [lprs_pkg::TIM_W:0]         rem_sh;
    logic                             q_bit;
    logic [lprs_pkg::PROD_W:0]        pos_sum;
    logic [lprs_pkg::CMD_W-1:0]       fix_cmd;

    assign tick_stall   = (eng_reg != lprs_pkg::ENG_IDLE);
    assign tick_fire    = tick_valid && !tick_stall;
    assign wb_load      = (eng_reg == lprs_pkg::ENG_WB) && (!res_valid_reg || !result_stall);
    assign result_valid = res_valid_reg;
    assign result       = res_item_reg;

    assign t_inc   = timer_reg + 8'd1;
    assign t_sat   = (timer_reg == lprs_pkg::TIM_MAX) ? lprs_pkg::TIM_MAX : t_inc;
    assign att_sat = (attempts_reg == lprs_pkg::TIM_MAX) ? lprs_pkg::TIM_MAX
                                                         : attempts_reg + 8'd1;

    assign dt_s     = {1'b0, t_inc} - {1'b0, tick.hold_time};
    assign span_s   = {1'b0, tick.ramp_time} - {1'b0, tick.hold_time};
    assign diff_s   = {1'b0, tick.ramp_to} - {1'b0, tick.ramp_from};
    assign dt_mag   = dt_s[lprs_pkg::TIM_W] ? lprs_pkg::TIM_W'(-dt_s)
                                            : dt_s[lprs_pkg::TIM_W-1:0];
    assign span_mag = span_s[lprs_pkg::TIM_W] ? lprs_pkg::TIM_W'(-span_s)
                                              : span_s[lprs_pkg::TIM_W-1:0];
    assign diff_mag = diff_s[lprs_pkg::CMD_W] ? lprs_pkg::CMD_W'(-diff_s)
                                              : diff_s[lprs_pkg::CMD_W-1:0];
    assign prod_neg = (diff_s[lprs_pkg::CMD_W] ^ dt_s[lprs_pkg::TIM_W])
                      && (diff_mag != '0) && (dt_mag != '0);

    // one restoring-division step
    assign rem_sh = {rem_reg, acc_reg[lprs_pkg::PROD_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, span_reg});

    // add the quotient to the ramp start, or subtract it when negative; clamp to command range
    assign pos_sum = {1'b0, acc_reg} + (lprs_pkg::PROD_W+1)'(from_reg);
    always_comb
    begin
        if (qneg_reg)
        begin
            if (acc_reg > lprs_pkg::PROD_W'(from_reg))
                fix_cmd = '0;
            else
                fix_cmd = from_reg - acc_reg[lprs_pkg::CMD_W-1:0];
        end
        else
        begin
            if (pos_sum > (lprs_pkg::PROD_W+1)'(lprs_pkg::CMD_MAX))
                fix_cmd = lprs_pkg::CMD_MAX;
            else
                fix_cmd = pos_sum[lprs_pkg::CMD_W-1:0];
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        timer_next     = timer_reg;
        attempts_next  = attempts_reg;
        cmd_next       = cmd_reg;
        finished_next  = finished_reg;
        eng_next       = eng_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        span_next      = span_reg;
        rem_next       = rem_reg;
        from_next      = from_reg;
        qneg_next      = qneg_reg;
        res_valid_next = res_valid_reg && result_stall;
        res_item_next  = res_item_reg;

        case (eng_reg)
            lprs_pkg::ENG_IDLE:
            begin
                if (tick_fire)
                begin
                    eng_next = lprs_pkg::ENG_WB;
                    case (phase_reg)
                        lprs_pkg::PH_IDLE:
                        begin
                            if (tick.enable)
                            begin
                                finished_next = 1'b0;
                                attempts_next = '0;
                                phase_next    = lprs_pkg::PH_HOLD;
                                cmd_next      = tick.start_command;
                                timer_next    = '0;
                            end
                        end
                        lprs_pkg::PH_HOLD, lprs_pkg::PH_RAMP, lprs_pkg::PH_STAB:
                        begin
                            if (!tick.enable)
                            begin
                                attempts_next = '0;
                                finished_next = 1'b1;
                                phase_next    = lprs_pkg::PH_IDLE;
                            end
                            else if (phase_reg == lprs_pkg::PH_HOLD)
                            begin
                                if (timer_reg >= tick.hold_time)
                                begin
                                    phase_next = lprs_pkg::PH_RAMP;
                                    cmd_next   = tick.ramp_from;
                                end
                                timer_next = t_sat;
                            end
                            else if (phase_reg == lprs_pkg::PH_RAMP)
                            begin
                                if (timer_reg >= tick.ramp_time)
                                begin
                                    timer_next    = t_sat;
                                    phase_next    = lprs_pkg::PH_STAB;
                                    cmd_next      = tick.settle_command;
                                    attempts_next = att_sat;
                                end
                                else
                                begin
                                    timer_next = t_inc;
                                    if (span_mag == '0)
                                    begin
                                        // zero span: sign of the product decides
                                        cmd_next = prod_neg ? '0 : lprs_pkg::CMD_MAX;
                                    end
                                    else
                                    begin
                                        eng_next    = lprs_pkg::ENG_MUL;
                                        cnt_next    = '0;
                                        acc_next    = '0;
                                        mcand_next  = lprs_pkg::PROD_W'(diff_mag);
                                        mplier_next = dt_mag;
                                        span_next   = span_mag;
                                        from_next   = tick.ramp_from;
                                        qneg_next   = prod_neg ^ span_s[lprs_pkg::TIM_W];
                                    end
                                end
                            end
                            else
                            begin
                                if (timer_reg >= tick.settle_time)
                                begin
                                    if (attempts_reg >= tick.attempt_limit)
                                    begin
                                        phase_next    = lprs_pkg::PH_END;
                                        finished_next = 1'b1;
                                    end
                                    else
                                    begin
                                        phase_next = lprs_pkg::PH_HOLD;
                                        cmd_next   = tick.start_command;
                                        timer_next = '0;
                                    end
                                end
                                else
                                begin
                                    timer_next = t_inc;
                                end
                            end
                        end
                        default:
                        begin
                            phase_next = lprs_pkg::PH_IDLE;
                        end
                    endcase
                end
            end
            lprs_pkg::ENG_MUL:
            begin
                // shift and add, one multiplier bit per cycle
                if (mplier_reg[0])
                    acc_next = acc_reg + mcand_reg;
                mcand_next  = {mcand_reg[lprs_pkg::PROD_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[lprs_pkg::TIM_W-1:1]};
                cnt_next    = cnt_reg + 5'd1;
                if (cnt_reg == lprs_pkg::CNT_W'(lprs_pkg::MUL_STEPS - 1))
                begin
                    eng_next = lprs_pkg::ENG_DIV;
                    cnt_next = '0;
                    rem_next = '0;
                end
            end
            lprs_pkg::ENG_DIV:
            begin
                // quotient bits shift in from the bottom as dividend bits leave the top
                rem_next = q_bit ? lprs_pkg::TIM_W'(rem_sh - {1'b0, span_reg})
                                 : rem_sh[lprs_pkg::TIM_W-1:0];
                acc_next = {acc_reg[lprs_pkg::PROD_W-2:0], q_bit};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == lprs_pkg::CNT_W'(lprs_pkg::DIV_STEPS - 1))
                    eng_next = lprs_pkg::ENG_FIX;
            end
            lprs_pkg::ENG_FIX:
            begin
                cmd_next = fix_cmd;
                eng_next = lprs_pkg::ENG_WB;
            end
            lprs_pkg::ENG_WB:
            begin
                if (wb_load)
                begin
                    res_valid_next             = 1'b1;
                    res_item_next.command      = cmd_reg;
                    res_item_next.done_flag    = finished_reg;
                    res_item_next.phase_out    = phase_reg;
                    res_item_next.attempts_out = attempts_reg;
                    res_item_next.timer_out    = timer_reg;
                    eng_next                   = lprs_pkg::ENG_IDLE;
                end
            end
            default:
            begin
                eng_next = lprs_pkg::ENG_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= lprs_pkg::PH_IDLE;
            timer_reg     <= '0;
            attempts_reg  <= '0;
            cmd_reg       <= '0;
            finished_reg  <= 1'b0;
            eng_reg       <= lprs_pkg::ENG_IDLE;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            timer_reg     <= timer_next;
            attempts_reg  <= attempts_next;
            cmd_reg       <= cmd_next;
            finished_reg  <= finished_next;
            eng_reg       <= eng_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        mcand_reg    <= mcand_next;
        mplier_reg   <= mplier_next;
        span_reg     <= span_next;
        rem_reg      <= rem_next;
        from_reg     <= from_next;
        qneg_reg     <= qneg_next;
        res_item_reg <= res_item_next;
    end

    // ---------------- assertions ----------------
    // the arithmetic engine only runs for a ramp interpolation
    a_eng_ramp: assert property (@(posedge clk) disable iff (!rst_n)
        (eng_reg == lprs_pkg::ENG_MUL || eng_reg == lprs_pkg::ENG_DIV ||
         eng_reg == lprs_pkg::ENG_FIX) |-> (phase_reg == lprs_pkg::PH_RAMP))
        else $error("engine busy outside ramp phase");

    // restoring divider keeps its remainder below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (eng_reg == lprs_pkg::ENG_DIV) |-> (rem_reg < span_reg))
        else $error("divider remainder out of range");

    // done flag is only seen in idle or end
    a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |-> (phase_reg == lprs_pkg::PH_IDLE || phase_reg == lprs_pkg::PH_END))
        else $error("done flag set in an active phase");

    // an accepted tick holds off the next one until its result is written
    a_tick_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tick_fire |=> (tick_stall && !wb_load || eng_reg == lprs_pkg::ENG_WB))
        else $error("tick accepted while previous one in work");

    // write-back raises the result valid in the next cycle
    a_wb_valid: assert property (@(posedge clk) disable iff (!rst_n)
        wb_load |=> (result_valid && !tick_stall))
        else $error("write-back lost");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the locking pin release sequencer
// Streams control ticks into the block and drains the results. Both sides
// idle at random. Each result is checked field by field against an in-bench
// model of the hold / ramp / stabilize / end sequence.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int RUN_LIMIT    = 300000;  // cycles; far above the slowest run
    localparam int DRAIN_CYCLES = 40;      // longer than one ramp tick
    localparam int LONG_HOLDOFF = 400;     // receiver hold-off, in cycles
    localparam int HOLDOFF_AT   = 150;     // items taken before the hold-off
    localparam int RANDOM_TICKS = 700;
    localparam int MAX_REPORTS  = 10;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   tick_valid   = 1'b0;
    logic                   tick_stall;
    lprs_pkg::tick_item_t   tick         = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    lprs_pkg::result_item_t result;

    locking_pin_release_sequencer_top u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_stall   (tick_stall),
        .tick         (tick),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Sequencer model: state as it stands after reset
    // ------------------------------------------------------------------------
    lprs_pkg::phase_t           seq_phase    = lprs_pkg::PH_IDLE;
    logic [lprs_pkg::TIM_W-1:0] seq_timer    = '0;
    logic [lprs_pkg::TIM_W-1:0] seq_attempts = '0;
    logic [lprs_pkg::CMD_W-1:0] seq_command  = '0;
    logic                       seq_finished = 1'b0;

    lprs_pkg::tick_item_t   pending_ticks[$];      // filled up front, drained by the driver
    lprs_pkg::result_item_t expected_results[$];   // one entry per accepted tick

    int ticks_taken = 0;
    int mismatches  = 0;
    int cycle_count = 0;

    function automatic logic [lprs_pkg::TIM_W-1:0] sat_step(logic [lprs_pkg::TIM_W-1:0] v);
        return (v == lprs_pkg::TIM_MAX) ? v : v + 1'b1;
    endfunction

    // Advance the model by one tick and return the result it produces.
    function automatic lprs_pkg::result_item_t sequence_tick(lprs_pkg::tick_item_t t);
        lprs_pkg::result_item_t r;
        int                     prod;
        int                     span;
        int                     val;
        case (seq_phase)
            lprs_pkg::PH_IDLE:
            begin
                if (t.enable)
                begin
                    seq_finished = 1'b0;
                    seq_attempts = '0;
                    seq_phase    = lprs_pkg::PH_HOLD;
                    seq_command  = t.start_command;
                    seq_timer    = '0;
                end
            end
            lprs_pkg::PH_HOLD, lprs_pkg::PH_RAMP, lprs_pkg::PH_STAB:
            begin
                if (!t.enable)
                begin
                    // abort: command and timer are kept
                    seq_attempts = '0;
                    seq_finished = 1'b1;
                    seq_phase    = lprs_pkg::PH_IDLE;
                end
                else if (seq_phase == lprs_pkg::PH_HOLD)
                begin
                    if (seq_timer >= t.hold_time)
                    begin
                        seq_phase   = lprs_pkg::PH_RAMP;
                        seq_command = t.ramp_from;
                    end
                    seq_timer = sat_step(seq_timer);
                end
                else if (seq_phase == lprs_pkg::PH_RAMP)
                begin
                    if (seq_timer >= t.ramp_time)
                    begin
                        seq_timer    = sat_step(seq_timer);
                        seq_phase    = lprs_pkg::PH_STAB;
                        seq_command  = t.settle_command;
                        seq_attempts = sat_step(seq_attempts);
                    end
                    else
                    begin
                        seq_timer = seq_timer + 1'b1;
                        prod = (int'(t.ramp_to) - int'(t.ramp_from))
                             * (int'(seq_timer) - int'(t.hold_time));
                        span = int'(t.ramp_time) - int'(t.hold_time);
                        if (span != 0)
                            val = prod / span + int'(t.ramp_from);
                        else
                            val = (prod < 0) ? 0 : int'(lprs_pkg::CMD_MAX);
                        if (val < 0)
                            val = 0;
                        if (val > int'(lprs_pkg::CMD_MAX))
                            val = int'(lprs_pkg::CMD_MAX);
                        seq_command = val[lprs_pkg::CMD_W-1:0];
                    end
                end
                else
                begin
                    if (seq_timer >= t.settle_time)
                    begin
                        if (seq_attempts >= t.attempt_limit)
                        begin
                            seq_phase    = lprs_pkg::PH_END;
                            seq_finished = 1'b1;
                        end
                        else
                        begin
                            // too few attempts: go round again
                            seq_phase   = lprs_pkg::PH_HOLD;
                            seq_command = t.start_command;
                            seq_timer   = '0;
                        end
                    end
                    else
                        seq_timer = seq_timer + 1'b1;
                end
            end
            default:
                seq_phase = lprs_pkg::PH_IDLE;   // end, and any unused code
        endcase
        r.command      = seq_command;
        r.done_flag    = seq_finished;
        r.phase_out    = seq_phase;
        r.attempts_out = seq_attempts;
        r.timer_out    = seq_timer;
        return r;
    endfunction

    function automatic lprs_pkg::tick_item_t make_tick(bit en, int hold, int ramp,
                                                       int settle, int limit, int start,
                                                       int from, int to, int stab);
        lprs_pkg::tick_item_t t;
        t.enable         = en;
        t.hold_time      = hold[lprs_pkg::TIM_W-1:0];
        t.ramp_time      = ramp[lprs_pkg::TIM_W-1:0];
        t.settle_time    = settle[lprs_pkg::TIM_W-1:0];
        t.attempt_limit  = limit[lprs_pkg::TIM_W-1:0];
        t.start_command  = start[lprs_pkg::CMD_W-1:0];
        t.ramp_from      = from[lprs_pkg::CMD_W-1:0];
        t.ramp_to        = to[lprs_pkg::CMD_W-1:0];
        t.settle_command = stab[lprs_pkg::CMD_W-1:0];
        return t;
    endfunction

    // Commands lean toward the rails now and then.
    function automatic int pick_command();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return int'(lprs_pkg::CMD_MAX);
            default: return $urandom_range(0, int'(lprs_pkg::CMD_MAX));
        endcase
    endfunction

    function automatic lprs_pkg::tick_item_t noise_tick(bit en);
        return make_tick(en, $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 1023), $urandom_range(0, 1023),
                         $urandom_range(0, 1023), $urandom_range(0, 1023));
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offers pending ticks in bursts with random gaps. An offered
    // item stays on the port until the block takes it.
    // ------------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            tick_valid <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (tick_valid && !tick_stall)
            begin
                expected_results.push_back(sequence_tick(tick));
                ticks_taken <= ticks_taken + 1;
            end
            if (tick_valid && tick_stall)
            begin
                // held; nothing changes
            end
            else if (gap_left != 0)
            begin
                gap_left   <= gap_left - 1;
                tick_valid <= 1'b0;
            end
            else if (pending_ticks.size() != 0)
            begin
                tick       <= pending_ticks.pop_front();
                tick_valid <= 1'b1;
                if (burst_left == 0)
                begin
                    // end of burst; a quarter of bursts run on with no gap
                    burst_left <= $urandom_range(0, 30);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                tick_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver stall pattern: stretches of 0 %, 30 % or 70 % stall, plus one
    // long hold-off so the block backs up and stalls its input.
    // ------------------------------------------------------------------------
    int stall_pct    = 0;
    int pattern_left = 0;
    int holdoff_left = 0;
    bit holdoff_done = 1'b0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_pct    <= 0;
            pattern_left <= 0;
            holdoff_left <= 0;
            holdoff_done <= 1'b0;
        end
        else
        begin
            if (pattern_left == 0)
            begin
                pattern_left <= $urandom_range(16, 96);
                case ($urandom_range(0, 2))
                    0:       stall_pct <= 0;
                    1:       stall_pct <= 30;
                    default: stall_pct <= 70;
                endcase
            end
            else
                pattern_left <= pattern_left - 1;

            if (holdoff_left != 0)
            begin
                holdoff_left <= holdoff_left - 1;
                result_stall <= 1'b1;
            end
            else if (!holdoff_done && ticks_taken >= HOLDOFF_AT)
            begin
                holdoff_done <= 1'b1;
                holdoff_left <= LONG_HOLDOFF;
                result_stall <= 1'b1;
            end
            else
                result_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: every accepted result against the oldest expectation
    // ------------------------------------------------------------------------
    lprs_pkg::result_item_t due_result;

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < MAX_REPORTS)
                    $display("unexpected result: cmd=%0d done=%0d phase=%0d att=%0d tmr=%0d",
                             result.command, result.done_flag, result.phase_out,
                             result.attempts_out, result.timer_out);
            end
            else
            begin
                due_result = expected_results.pop_front();
                if (result.command      !== due_result.command      ||
                    result.done_flag    !== due_result.done_flag    ||
                    result.phase_out    !== due_result.phase_out    ||
                    result.attempts_out !== due_result.attempts_out ||
                    result.timer_out    !== due_result.timer_out)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < MAX_REPORTS)
                    begin
                        $display("mismatch: expected cmd=%0d done=%0d phase=%0d att=%0d tmr=%0d",
                                 due_result.command, due_result.done_flag,
                                 due_result.phase_out, due_result.attempts_out,
                                 due_result.timer_out);
                        $display("          got      cmd=%0d done=%0d phase=%0d att=%0d tmr=%0d",
                                 result.command, result.done_flag, result.phase_out,
                                 result.attempts_out, result.timer_out);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        lprs_pkg::tick_item_t base;
        lprs_pkg::tick_item_t cur;
        int                   random_count;
        int                   run_no;
        int                   n;
        int                   k;
        int                   pick;
        int                   val;
        int                   h;
        int                   r;
        int                   s;
        int                   lim;
        bit                   big;

        // Directed: ignored tick in idle with every field but enable at its top value
        pending_ticks.push_back(make_tick(1'b0, 255, 255, 255, 255, 1023, 1023, 1023, 1023));
        // Full pass: hold, rising ramp with truncation, stabilize, then a
        // retry because only one of two attempts is done
        repeat (9)
            pending_ticks.push_back(make_tick(1'b1, 1, 5, 7, 2, 1023, 0, 1023, 512));
        // Retry enters ramp from the top, then the set-points move under it:
        // zero span with positive and negative product, then hold above the
        // timer clamping high and low
        pending_ticks.push_back(make_tick(1'b1, 0, 0, 0, 0, 0, 1023, 0, 0));
        pending_ticks.push_back(make_tick(1'b1, 9, 9, 0, 0, 0, 1023, 0, 0));
        pending_ticks.push_back(make_tick(1'b1, 9, 9, 0, 0, 0, 0, 1023, 0));
        pending_ticks.push_back(make_tick(1'b1, 20, 10, 0, 0, 0, 0, 1023, 0));
        pending_ticks.push_back(make_tick(1'b1, 20, 30, 0, 0, 0, 0, 1023, 0));
        // Abort in ramp
        pending_ticks.push_back(make_tick(1'b0, 0, 0, 0, 0, 0, 0, 0, 0));
        // Shortest complete sequence: hold, ramp, stabilize, end, idle
        repeat (5)
            pending_ticks.push_back(make_tick(1'b1, 0, 0, 0, 0, 0, 1023, 0, 1023));
        // Abort in hold
        pending_ticks.push_back(make_tick(1'b1, 0, 0, 0, 0, 1023, 0, 0, 0));
        pending_ticks.push_back(make_tick(1'b0, 0, 0, 0, 0, 0, 0, 0, 0));
        // Abort in stabilize
        repeat (4)
            pending_ticks.push_back(make_tick(1'b1, 0, 0, 255, 255, 512, 0, 1023, 1023));
        pending_ticks.push_back(make_tick(1'b0, 0, 0, 0, 0, 0, 0, 0, 0));

        // Random: mostly complete sequences with set-points held per run and
        // the odd one nudged mid-run, some cut short, some pure noise
        random_count = 0;
        run_no       = 0;
        while (random_count < RANDOM_TICKS)
        begin
            run_no++;
            if ($urandom_range(0, 6) == 0)
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                    pending_ticks.push_back(noise_tick($urandom_range(0, 1)));
                random_count += n;
            end
            else
            begin
                // an occasional run holds long enough to saturate the timer
                big = (run_no == 4) || ($urandom_range(0, 59) == 0);
                if (big)
                begin
                    h   = $urandom_range(240, 255);
                    r   = 255;
                    s   = 255;
                    lim = 1;
                end
                else
                begin
                    h   = $urandom_range(0, 6);
                    r   = h + $urandom_range(0, 8);
                    s   = r + $urandom_range(0, 6);
                    lim = $urandom_range(0, 4);
                end
                base = make_tick(1'b1, h, r, s, lim, pick_command(), pick_command(),
                                 pick_command(), pick_command());
                n = ((lim > 1) ? lim : 1) * (s + 4) + 3;
                if (n > 300)
                    n = 300;
                if ($urandom_range(0, 9) == 0)
                    n = $urandom_range(1, n);   // cut short, ends in an abort
                repeat (n)
                begin
                    cur  = base;
                    pick = big ? 99 : $urandom_range(0, 19);
                    val  = $urandom_range(0, 20);
                    if (pick == 0)
                        cur.hold_time = val[lprs_pkg::TIM_W-1:0];
                    else if (pick == 1)
                        cur.ramp_time = cur.hold_time;
                    else if (pick == 2)
                        cur.ramp_to = pick_command();
                    pending_ticks.push_back(cur);
                end
                // a few disabled ticks close the run
                k = $urandom_range(1, 3);
                repeat (k)
                    pending_ticks.push_back(noise_tick(1'b0));
                random_count += n + k;
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_ticks.size() != 0 || tick_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
